// ===== design/ofbf_pkg.sv =====
`default_nettype none

package ofbf_pkg;

    // Input item kinds, carried on s_tuser
    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_TICK  = 2'd3
    } item_cmd_t;

    // Transaction queue phase
    typedef enum logic [2:0] {
        Q_IDLE  = 3'd0,
        Q_INIT  = 3'd1,
        Q_PAGE  = 3'd2,
        Q_COLHI = 3'd3,
        Q_COLLO = 3'd4,
        Q_DATA  = 3'd5
    } qphase_t;

    // Item handling state of the controller
    typedef enum logic [1:0] {
        CS_CLEAR  = 2'd0,
        CS_IDLE   = 2'd1,
        CS_PIX_WR = 2'd2,
        CS_EMIT   = 2'd3
    } ctrl_state_t;

    localparam int S_TDATA_W = 40;

    localparam logic [4:0] INIT_LAST_STEP = 5'd27;
    localparam logic [4:0] CONTRAST_STEP  = 5'd9;
    localparam logic [7:0] PAGE_CMD       = 8'hB0;
    localparam logic [7:0] COLHI_CMD      = 8'h10;

    // Controller to datapath
    typedef struct packed {
        logic    accept;
        logic    rd_pix;
        logic    wr_pix;
        logic    clr_en;
        logic    load_region;
        logic    load_full;
        logic    init_clr;
        logic    step_inc;
        logic    col_clr;
        logic    col_inc;
        logic    page_inc;
        logic    emit;
        logic    emit_last;
        qphase_t emit_sel;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        item_cmd_t in_cmd;
        logic      pix_ok;
        logic      flush_ok;
        logic      clr_done;
        logic      out_free;
        logic      init_last;
        logic      span_zero;
        logic      col_last;
        logic      half_last;
    } dp_sts_t;

    // Panel start sequence; the contrast slot is replaced by the register
    function automatic logic [7:0] start_cmd(input logic [4:0] step);
        logic [7:0] b;
        unique case (step)
            5'd0:    b = 8'hAE;
            5'd1:    b = 8'h20;
            5'd2:    b = 8'h10;
            5'd3:    b = 8'hB0;
            5'd4:    b = 8'hC8;
            5'd5:    b = 8'h00;
            5'd6:    b = 8'h10;
            5'd7:    b = 8'h40;
            5'd8:    b = 8'h81;
            5'd9:    b = 8'hFF;
            5'd10:   b = 8'hA1;
            5'd11:   b = 8'hA6;
            5'd12:   b = 8'hA8;
            5'd13:   b = 8'h3F;
            5'd14:   b = 8'hA4;
            5'd15:   b = 8'hD3;
            5'd16:   b = 8'h00;
            5'd17:   b = 8'hD5;
            5'd18:   b = 8'hF0;
            5'd19:   b = 8'hD9;
            5'd20:   b = 8'h22;
            5'd21:   b = 8'hDA;
            5'd22:   b = 8'h12;
            5'd23:   b = 8'hDB;
            5'd24:   b = 8'h20;
            5'd25:   b = 8'h8D;
            5'd26:   b = 8'h14;
            default: b = 8'hAF;
        endcase
        return b;
    endfunction

    // Spread a nibble onto the odd bits of a byte
    function automatic logic [7:0] spread_nibble(input logic [3:0] v);
        return {v[3], 1'b0, v[2], 1'b0, v[1], 1'b0, v[0], 1'b0};
    endfunction

endpackage

`default_nettype wire

// ===== design/ofbf_ctrl.sv =====
`default_nettype none

module ofbf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire ofbf_pkg::dp_sts_t sts,
    output ofbf_pkg::dp_cmd_t     cmd
);
    import ofbf_pkg::*;

    ctrl_state_t state_reg, state_next;
    qphase_t     qphase_reg, qphase_next;

    // State registers; reset starts with a clearing pass of the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= CS_CLEAR;
            qphase_reg <= Q_IDLE;
        end else begin
            state_reg  <= state_next;
            qphase_reg <= qphase_next;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        qphase_next  = qphase_reg;
        cmd          = '0;
        cmd.emit_sel = qphase_reg;
        s_tready     = (state_reg == CS_IDLE);

        unique case (state_reg)
            CS_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_done) state_next = CS_IDLE;
            end
            CS_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    unique case (sts.in_cmd)
                        CMD_PIXEL: begin
                            if (sts.pix_ok) begin
                                cmd.rd_pix = 1'b1;
                                state_next = CS_PIX_WR;
                            end
                        end
                        CMD_FLUSH: begin
                            if (qphase_reg == Q_IDLE && sts.flush_ok) begin
                                cmd.load_region = 1'b1;
                                qphase_next     = Q_PAGE;
                            end
                        end
                        CMD_INIT: begin
                            if (qphase_reg == Q_IDLE) begin
                                cmd.init_clr = 1'b1;
                                qphase_next  = Q_INIT;
                                state_next   = CS_CLEAR;
                            end
                        end
                        CMD_TICK: begin
                            if (qphase_reg != Q_IDLE) state_next = CS_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            CS_PIX_WR: begin
                cmd.wr_pix = 1'b1;
                state_next = CS_IDLE;
            end
            CS_EMIT: begin
                // Hold until the output register can take the transfer
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = CS_IDLE;
                    unique case (qphase_reg)
                        Q_INIT: begin
                            cmd.step_inc = 1'b1;
                            if (sts.init_last) begin
                                cmd.load_full = 1'b1;
                                qphase_next   = Q_PAGE;
                            end
                        end
                        Q_PAGE:  qphase_next = Q_COLHI;
                        Q_COLHI: qphase_next = Q_COLLO;
                        Q_COLLO: begin
                            cmd.col_clr = 1'b1;
                            if (!sts.span_zero) begin
                                qphase_next = Q_DATA;
                            end else begin
                                cmd.page_inc  = 1'b1;
                                cmd.emit_last = sts.half_last;
                                qphase_next   = sts.half_last ? Q_IDLE : Q_PAGE;
                            end
                        end
                        Q_DATA: begin
                            cmd.col_inc = 1'b1;
                            if (sts.col_last) begin
                                cmd.page_inc  = 1'b1;
                                cmd.emit_last = sts.half_last;
                                qphase_next   = sts.half_last ? Q_IDLE : Q_PAGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // A result is loaded only into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.emit |-> sts.out_free)
        else $error("emit while output register busy");

    // A store write for a pixel follows an accepted on-screen pixel item
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_pix |-> $past(cmd.accept && cmd.rd_pix))
        else $error("pixel write without its read");

    // Data phase is never entered for an empty region
    assert property (@(posedge aclk) disable iff (!aresetn)
        (qphase_reg == Q_DATA) |-> !sts.span_zero)
        else $error("data phase with zero span");

    // An emit wait always has something queued
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_EMIT) |-> (qphase_reg != Q_IDLE))
        else $error("emit wait with empty queue");

endmodule

`default_nettype wire

// ===== design/ofbf_datapath.sv =====
`default_nettype none

module ofbf_datapath #(
    parameter int PAGES   = 4,
    parameter int COLUMNS = 128
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [ofbf_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic [1:0]                          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,
    output logic [0:0]                               m_tuser,
    output logic                                     m_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [7:0]                          cfg_data,
    input  wire ofbf_pkg::dp_cmd_t                   cmd,
    output ofbf_pkg::dp_sts_t                        sts
);
    import ofbf_pkg::*;

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(2 * PAGES + 1);
    localparam int RPW   = $clog2(PAGES + 1);

    // Input fields
    logic [7:0] in_x, in_y, in_w, in_h;
    logic       in_pix;
    assign in_x   = s_tdata[7:0];
    assign in_y   = s_tdata[15:8];
    assign in_w   = s_tdata[23:16];
    assign in_h   = s_tdata[31:24];
    assign in_pix = s_tdata[32];

    logic [7:0]     contrast_reg;
    logic [AW-1:0]  clr_cnt_reg;
    logic [AW-1:0]  pix_addr_reg;
    logic [2:0]     pix_bit_reg;
    logic           pix_val_reg;
    logic [4:0]     step_reg;
    logic [PW-1:0]  page_cursor_reg;
    logic [RPW-1:0] region_pages_reg;
    logic [7:0]     origin_reg;
    logic [7:0]     span_reg;
    logic [7:0]     col_reg;
    logic [7:0]     rd_data_reg;
    logic           m_tvalid_reg;
    logic [7:0]     m_tdata_reg;
    logic           m_tuser_reg;
    logic           m_tlast_reg;

    logic [7:0] mem [DEPTH];

    // Pixel address and range check
    logic [15:0] pix_addr_full;
    logic        pix_ok;
    assign pix_ok        = ({1'b0, in_x} < 9'(COLUMNS)) && ({3'b0, in_y[7:3]} < 8'(PAGES));
    assign pix_addr_full = 16'(in_y[7:3]) * 16'(COLUMNS) + 16'(in_x);

    // Flush region setup
    logic [8:0]     yh_sum;
    logic [6:0]     end_page;
    logic [RPW-1:0] region_pages_next;
    logic [8:0]     col_room;
    logic [7:0]     span_next;
    logic           flush_ok;
    always_comb begin
        yh_sum   = {1'b0, in_y} + {1'b0, in_h};
        end_page = {1'b0, yh_sum[8:3]} + 7'd1;
        region_pages_next = (end_page > 7'(PAGES)) ? RPW'(PAGES) : RPW'(end_page);
        flush_ok = ({3'b0, in_y[7:3]} < 8'(PAGES));
        col_room = 9'(COLUMNS) - {1'b0, in_x};
        if ({1'b0, in_x} >= 9'(COLUMNS)) begin
            span_next = 8'd0;
        end else if ({1'b0, in_w} > col_room) begin
            span_next = col_room[7:0];
        end else begin
            span_next = in_w;
        end
    end

    // Queue cursor status
    logic [PW-1:0] pc_inc;
    logic [15:0]   data_addr_full;
    logic          half_last;
    logic          col_last;
    logic          init_last;
    assign pc_inc         = page_cursor_reg + PW'(1);
    assign half_last      = 8'(pc_inc[PW-1:1]) >= 8'(region_pages_reg);
    assign col_last       = ({1'b0, col_reg} + 9'd1) >= {1'b0, span_reg};
    assign init_last      = (step_reg == INIT_LAST_STEP);
    assign data_addr_full = 16'(page_cursor_reg[PW-1:1]) * 16'(COLUMNS)
                          + 16'(origin_reg) + 16'(col_reg);

    // Frame store ports: one write, one registered read
    logic [7:0]    pix_mask;
    logic [7:0]    wr_data;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    always_comb begin
        pix_mask = 8'd1 << pix_bit_reg;
        if (cmd.clr_en) begin
            wr_addr = clr_cnt_reg;
            wr_data = 8'd0;
        end else begin
            wr_addr = pix_addr_reg;
            wr_data = pix_val_reg ? (rd_data_reg | pix_mask) : (rd_data_reg & ~pix_mask);
        end
        wr_en   = cmd.clr_en | cmd.wr_pix;
        rd_addr = cmd.rd_pix ? pix_addr_full[AW-1:0] : data_addr_full[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Clearing sweep counter, wraps to zero after the last entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_cnt_reg <= (clr_cnt_reg == AW'(DEPTH - 1)) ? '0 : clr_cnt_reg + AW'(1);
        end
    end

    // Capture the pixel item for the write-back cycle
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_addr_reg <= pix_addr_full[AW-1:0];
            pix_bit_reg  <= in_y[2:0];
            pix_val_reg  <= in_pix;
        end
    end

    // Contrast register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contrast_reg <= 8'hFF;
        end else if (cfg_valid) begin
            contrast_reg <= cfg_data;
        end
    end

    // Queue cursors
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg         <= '0;
            page_cursor_reg  <= '0;
            region_pages_reg <= '0;
            origin_reg       <= '0;
            span_reg         <= '0;
            col_reg          <= '0;
        end else begin
            if (cmd.init_clr) begin
                step_reg <= '0;
            end else if (cmd.step_inc) begin
                step_reg <= init_last ? 5'd0 : step_reg + 5'd1;
            end
            if (cmd.load_region) begin
                page_cursor_reg  <= PW'({in_y[7:3], 1'b0});
                region_pages_reg <= region_pages_next;
                origin_reg       <= in_x;
                span_reg         <= span_next;
                col_reg          <= 8'd0;
            end else if (cmd.load_full) begin
                page_cursor_reg  <= '0;
                region_pages_reg <= RPW'(PAGES);
                origin_reg       <= 8'd0;
                span_reg         <= 8'(COLUMNS);
                col_reg          <= 8'd0;
            end else begin
                if (cmd.page_inc) page_cursor_reg <= pc_inc;
                if (cmd.col_clr) begin
                    col_reg <= 8'd0;
                end else if (cmd.col_inc) begin
                    col_reg <= col_reg + 8'd1;
                end
            end
        end
    end

    // Result byte for the current queue phase
    logic [7:0] payload_next;
    logic       is_data_next;
    always_comb begin
        payload_next = 8'd0;
        is_data_next = 1'b0;
        unique case (cmd.emit_sel)
            Q_INIT:  payload_next = (step_reg == CONTRAST_STEP) ? contrast_reg
                                                                : start_cmd(step_reg);
            Q_PAGE:  payload_next = PAGE_CMD + 8'(page_cursor_reg);
            Q_COLHI: payload_next = COLHI_CMD + {4'b0, origin_reg[7:4]};
            Q_COLLO: payload_next = {4'b0, origin_reg[3:0]};
            Q_DATA: begin
                is_data_next = 1'b1;
                payload_next = spread_nibble(page_cursor_reg[0] ? rd_data_reg[7:4]
                                                                : rd_data_reg[3:0]);
            end
            default: ;
        endcase
    end

    // Output register: load on emit, drop after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= payload_next;
            m_tuser_reg <= is_data_next;
            m_tlast_reg <= cmd.emit_last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    // Status to the controller
    always_comb begin
        sts           = '0;
        sts.in_cmd    = item_cmd_t'(s_tuser);
        sts.pix_ok    = pix_ok;
        sts.flush_ok  = flush_ok;
        sts.clr_done  = (clr_cnt_reg == AW'(DEPTH - 1));
        sts.out_free  = !m_tvalid_reg || m_tready;
        sts.init_last = init_last;
        sts.span_zero = (span_reg == 8'd0);
        sts.col_last  = col_last;
        sts.half_last = half_last;
    end

endmodule

`default_nettype wire

// ===== design/oled_frame_buffer_flusher.sv =====
`default_nettype none

// Page-mode OLED frame store with a transaction queue. Items arrive on the
// s_ stream (s_tuser selects pixel write, flush, init or tick); each tick
// while the queue is busy gives one transaction on the m_ stream, with
// m_tuser set for a data byte and m_tlast on the final transaction of a
// flush or init. The store is one memory with a single registered read
// port, so a pixel write reads the byte, then modifies and writes it back;
// a tick waits in the emit state for the output register to free up, and
// a flush or an ignored item needs no further state. Init and reset both
// run a clearing pass over all PAGES*COLUMNS store entries (512 by default),
// during which s_tready is low; contrast writes are taken at any time.
module oled_frame_buffer_flusher #(
    parameter int PAGES   = 4,
    parameter int COLUMNS = 128
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // x [7:0], y [15:8], width [23:16], height [31:24], pixel [32], zero [39:33]
    input  wire logic [ofbf_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd [1:0]
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // payload [7:0]
    output logic [7:0]                          m_tdata,
    // is_data [0]
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [7:0]                     cfg_data
);
    import ofbf_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    ofbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    ofbf_datapath #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

endmodule

`default_nettype wire

// ===== verif/oled_frame_buffer_flusher_test.sv =====
`default_nettype none

module oled_frame_buffer_flusher_test;
    import ofbf_pkg::*;

    localparam int PANEL_PAGES   = 4;
    localparam int PANEL_COLS    = 128;
    localparam int BOOT_LEN      = 28;
    localparam int CONTRAST_SLOT = 9;
    localparam logic [7:0] PAGE_BASE   = 8'hB0;
    localparam logic [7:0] COL_HI_BASE = 8'h10;
    localparam logic [7:0] CONTRAST_RESET = 8'hFF;
    localparam int HOLD_CYCLES   = 300;
    // covers the clearing pass of an init plus the tick and pixel latency
    localparam int SETTLE_CYCLES = 600;
    localparam int TAIL_CYCLES   = 50;
    localparam int RANDOM_PHASES = 2;
    localparam int PHASE_ITEMS   = 150;

    typedef struct packed {
        logic       is_data;
        logic [7:0] payload;
        logic       last;
    } txn_t;

    typedef struct packed {
        item_cmd_t  cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
        logic       pix;
    } panel_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [7:0]           cfg_data;

    // Panel start sequence; the contrast slot is taken from the register
    logic [7:0] boot_seq [0:BOOT_LEN-1] = '{
        8'hAE, 8'h20, 8'h10, 8'hB0, 8'hC8, 8'h00, 8'h10, 8'h40, 8'h81, 8'hFF,
        8'hA1, 8'hA6, 8'hA8, 8'h3F, 8'hA4, 8'hD3, 8'h00, 8'hD5, 8'hF0, 8'hD9,
        8'h22, 8'hDA, 8'h12, 8'hDB, 8'h20, 8'h8D, 8'h14, 8'hAF
    };

    // Shadow of the block state
    logic [7:0]  fb_shadow [0:PANEL_PAGES*PANEL_COLS-1];
    qphase_t     q_phase;
    logic [4:0]  boot_idx;
    logic [5:0]  half_cursor;
    logic [7:0]  col_cursor;
    logic [7:0]  org_col;
    logic [15:0] span_cols;
    logic [5:0]  page_limit;
    logic [7:0]  contrast_shadow;

    txn_t panel_txns_due [$];

    int mismatches      = 0;
    int checked_txns    = 0;
    int sent_items      = 0;
    int effective_items = 0;
    int inits_run       = 0;
    int flushes_run     = 0;
    int pixel_writes    = 0;
    int cfg_writes      = 0;
    bit steady_run      = 1'b0;
    int hold_req        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int stall_left      = 0;

    oled_frame_buffer_flusher #(
        .PAGES(PANEL_PAGES),
        .COLUMNS(PANEL_COLS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int unsigned r;
        if (steady_run) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Compare each transfer with the oldest expected transaction
    always @(posedge aclk) begin
        txn_t want;
        if (aresetn && m_tvalid && m_tready) begin
            checked_txns++;
            if (panel_txns_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer, expected none, actual payload %h",
                         $time, m_tdata);
            end else begin
                want = panel_txns_due.pop_front();
                if (m_tuser[0] !== want.is_data) begin
                    mismatches++;
                    $display("%0t: is_data expected %b actual %b",
                             $time, want.is_data, m_tuser[0]);
                end
                if (m_tdata !== want.payload) begin
                    mismatches++;
                    $display("%0t: payload expected %h actual %h",
                             $time, want.payload, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    mismatches++;
                    $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                end
            end
        end
    end

    task automatic clear_shadow();
        for (int i = 0; i < PANEL_PAGES * PANEL_COLS; i++) fb_shadow[i] = 8'h00;
    endtask

    // Load a flush region into the shadow queue state
    task automatic open_region(input int first, input int stop, input int col, input int w);
        int span;
        if (stop > PANEL_PAGES) stop = PANEL_PAGES;
        if (first >= PANEL_PAGES || first >= stop) return;
        if (col >= PANEL_COLS) span = 0;
        else if (w > PANEL_COLS - col) span = PANEL_COLS - col;
        else span = w;
        half_cursor = 6'(first * 2);
        page_limit  = 6'(stop);
        org_col     = 8'(col);
        span_cols   = 16'(span);
        col_cursor  = 8'd0;
        q_phase     = Q_PAGE;
    endtask

    // Advance to the next half page; done is set when the queue runs out
    task automatic next_half_page(output bit done);
        half_cursor = half_cursor + 6'd1;
        if ((half_cursor >> 1) >= page_limit) begin
            q_phase = Q_IDLE;
            done = 1'b1;
        end else begin
            q_phase = Q_PAGE;
            done = 1'b0;
        end
    endtask

    // Apply one accepted item to the shadow and queue the transaction it causes
    task automatic panel_step(input panel_item_t it);
        txn_t       t;
        bit         emit;
        bit         done;
        int         yv;
        int         first;
        int         total;
        int         idx;
        int         s;
        logic [7:0] b;
        logic [3:0] nib;
        t = '0;
        emit = 1'b0;
        done = 1'b0;
        case (it.cmd)
            CMD_PIXEL: begin
                if (it.x < PANEL_COLS && (it.y >> 3) < PANEL_PAGES) begin
                    idx = int'(it.y >> 3) * PANEL_COLS + int'(it.x);
                    fb_shadow[idx][it.y[2:0]] = it.pix;
                    pixel_writes++;
                    effective_items++;
                end
            end
            CMD_FLUSH: begin
                if (q_phase == Q_IDLE) begin
                    yv = it.y;
                    first = yv >> 3;
                    total = ((yv + int'(it.h)) >> 3) - first + 1;
                    open_region(first, first + total, int'(it.x), int'(it.w));
                    if (q_phase != Q_IDLE) begin
                        flushes_run++;
                        effective_items++;
                    end
                end
            end
            CMD_INIT: begin
                if (q_phase == Q_IDLE) begin
                    clear_shadow();
                    boot_idx = 5'd0;
                    q_phase = Q_INIT;
                    inits_run++;
                    effective_items++;
                end
            end
            default: begin
                if (q_phase != Q_IDLE) begin
                    emit = 1'b1;
                    effective_items++;
                end
                case (q_phase)
                    Q_INIT: begin
                        s = boot_idx;
                        if (s >= BOOT_LEN) s = BOOT_LEN - 1;
                        t.payload = (s == CONTRAST_SLOT) ? contrast_shadow : boot_seq[s];
                        boot_idx = 5'(s + 1);
                        if (boot_idx >= BOOT_LEN) begin
                            boot_idx = 5'd0;
                            open_region(0, PANEL_PAGES, 0, PANEL_COLS);
                        end
                    end
                    Q_PAGE: begin
                        t.payload = PAGE_BASE + {2'b00, half_cursor};
                        q_phase = Q_COLHI;
                    end
                    Q_COLHI: begin
                        t.payload = COL_HI_BASE + {4'h0, org_col[7:4]};
                        q_phase = Q_COLLO;
                    end
                    Q_COLLO: begin
                        t.payload = {4'h0, org_col[3:0]};
                        col_cursor = 8'd0;
                        if (span_cols > 0) begin
                            q_phase = Q_DATA;
                        end else begin
                            next_half_page(done);
                            t.last = done;
                        end
                    end
                    Q_DATA: begin
                        idx = int'(half_cursor >> 1) * PANEL_COLS + int'(org_col)
                            + int'(col_cursor);
                        b = (idx < PANEL_PAGES * PANEL_COLS) ? fb_shadow[idx] : 8'h00;
                        nib = half_cursor[0] ? b[7:4] : b[3:0];
                        t.is_data = 1'b1;
                        t.payload = {nib[3], 1'b0, nib[2], 1'b0, nib[1], 1'b0, nib[0], 1'b0};
                        col_cursor = col_cursor + 8'd1;
                        if (col_cursor >= span_cols) begin
                            next_half_page(done);
                            t.last = done;
                        end
                    end
                    default: q_phase = Q_IDLE;
                endcase
            end
        endcase
        if (emit) panel_txns_due.push_back(t);
    endtask

    // Offer one item and hold it until the transfer; valid stays high afterwards
    task automatic send_item(input item_cmd_t cmd, input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] w, input logic [7:0] h, input logic pix);
        int          gap;
        panel_item_t it;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, pix, h, w, y, x};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        it.cmd = cmd;
        it.x = x;
        it.y = y;
        it.w = w;
        it.h = h;
        it.pix = pix;
        sent_items++;
        panel_step(it);
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, rand8(), rand8(), rand8(), rand8(), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_queue_out();
        while (q_phase != Q_IDLE) send_tick();
    endtask

    // Drop valid, let every expected transfer arrive and the block settle
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (panel_txns_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_contrast(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        contrast_shadow = v;
        cfg_writes++;
    endtask

    // Init at a zero contrast, with pixel writes and ignored items mid-flush
    task automatic test_init_sequence();
        write_contrast(8'h00);
        send_tick();
        send_item(CMD_INIT, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        repeat (60) send_tick();
        send_item(CMD_PIXEL, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PIXEL, 8'd127, 8'd31, 8'h00, 8'h00, 1'b1);
        send_item(CMD_INIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h10, 8'h08, 1'b0);
        run_queue_out();
        send_tick();
    endtask

    task automatic test_pixels_and_regions();
        send_item(CMD_PIXEL, 8'd0, 8'd31, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PIXEL, 8'd127, 8'd0, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PIXEL, 8'd124, 8'd9, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PIXEL, 8'd124, 8'd9, 8'h00, 8'h00, 1'b0);
        send_item(CMD_PIXEL, 8'd125, 8'd14, 8'h00, 8'h00, 1'b1);
        // off screen pixels are dropped
        send_item(CMD_PIXEL, 8'd128, 8'd0, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PIXEL, 8'd3, 8'd32, 8'h00, 8'h00, 1'b1);
        // width clipped at the right edge, all pages
        send_item(CMD_FLUSH, 8'd120, 8'd0, 8'hFF, 8'd31, 1'b0);
        run_queue_out();
        // columns off screen: address commands only
        send_item(CMD_FLUSH, 8'd200, 8'd8, 8'd10, 8'd0, 1'b0);
        run_queue_out();
        // zero width
        send_item(CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        run_queue_out();
        // region below the screen queues nothing
        send_item(CMD_FLUSH, 8'd0, 8'd40, 8'd4, 8'd4, 1'b0);
        send_item(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_tick();
        // height runs past the last page
        send_item(CMD_FLUSH, 8'd126, 8'd30, 8'd4, 8'hFF, 1'b0);
        run_queue_out();
    endtask

    task automatic test_busy_ignored();
        send_item(CMD_FLUSH, 8'd10, 8'd0, 8'd5, 8'd7, 1'b0);
        repeat (3) send_tick();
        send_item(CMD_FLUSH, 8'd0, 8'd0, 8'd1, 8'd0, 1'b0);
        send_item(CMD_INIT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_PIXEL, 8'd13, 8'd6, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PIXEL, 8'd11, 8'd2, 8'h00, 8'h00, 1'b1);
        run_queue_out();
    endtask

    // Hold the receiver off while ticks keep coming, so the input stalls
    task automatic test_output_stall();
        steady_run = 1'b1;
        hold_req++;
        send_item(CMD_FLUSH, 8'd0, 8'd0, 8'd20, 8'd7, 1'b0);
        run_queue_out();
        steady_run = 1'b0;
    endtask

    task automatic random_pixel();
        logic [7:0] x;
        logic [7:0] y;
        x = ($urandom_range(0, 9) == 0) ? rand8() : 8'($urandom_range(0, PANEL_COLS - 1));
        y = ($urandom_range(0, 9) == 0) ? rand8() : 8'($urandom_range(0, PANEL_PAGES * 8 - 1));
        send_item(CMD_PIXEL, x, y, rand8(), rand8(), 1'($urandom_range(0, 1)));
    endtask

    // Tick the queue empty with pixel writes and ignored items mixed in
    task automatic drain_with_noise();
        int unsigned r;
        while (q_phase != Q_IDLE) begin
            r = $urandom_range(0, 99);
            if (r < 85) send_tick();
            else if (r < 95) random_pixel();
            else if (r < 98) send_item(CMD_FLUSH, rand8(), rand8(), rand8(), rand8(), 1'b0);
            else send_item(CMD_INIT, rand8(), rand8(), rand8(), rand8(), 1'b0);
        end
    endtask

    task automatic random_flush();
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
        x = ($urandom_range(0, 4) == 0) ? rand8() : 8'($urandom_range(0, PANEL_COLS - 1));
        y = ($urandom_range(0, 6) == 0) ? rand8() : 8'($urandom_range(0, PANEL_PAGES * 8 - 1));
        w = ($urandom_range(0, 9) == 0) ? rand8() : 8'($urandom_range(0, 12));
        h = ($urandom_range(0, 9) == 0) ? rand8() : 8'($urandom_range(0, 9));
        send_item(CMD_FLUSH, x, y, w, h, 1'($urandom_range(0, 1)));
        drain_with_noise();
    endtask

    task automatic test_random_traffic();
        int          start;
        int unsigned r;
        int unsigned n;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_quiet();
            write_contrast((phase == RANDOM_PHASES - 1) ? CONTRAST_RESET : rand8());
            start = effective_items;
            while (effective_items - start < PHASE_ITEMS) begin
                steady_run = ($urandom_range(0, 7) == 0);
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    n = $urandom_range(1, 6);
                    repeat (n) random_pixel();
                end else if (r < 75) begin
                    random_flush();
                end else if (r < 85) begin
                    send_tick();
                end else if (r < 92) begin
                    send_item(CMD_PIXEL, 8'($urandom_range(PANEL_COLS, 255)), rand8(),
                              rand8(), rand8(), 1'b1);
                    send_item(CMD_FLUSH, rand8(), 8'($urandom_range(PANEL_PAGES * 8, 255)),
                              rand8(), rand8(), 1'b1);
                end else begin
                    // any item but init, all fields at random
                    send_item(item_cmd_t'(($urandom_range(0, 2) == 2) ? CMD_TICK
                                          : item_cmd_t'($urandom_range(0, 1))),
                              rand8(), rand8(), rand8(), rand8(), 1'($urandom_range(0, 1)));
                    drain_with_noise();
                end
            end
        end
        steady_run = 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_PIXEL;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'h00;
        clear_shadow();
        q_phase         = Q_IDLE;
        boot_idx        = 5'd0;
        half_cursor     = 6'd0;
        col_cursor      = 8'd0;
        org_col         = 8'd0;
        span_cols       = 16'd0;
        page_limit      = 6'd0;
        contrast_shadow = CONTRAST_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_init_sequence();
        test_pixels_and_regions();
        test_busy_ignored();
        test_output_stall();
        test_random_traffic();

        // Drain and give the block a few cycles for stray transfers
        s_tvalid <= 1'b0;
        while (panel_txns_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("tb: %0d items sent, %0d took effect, %0d transfers checked",
                 sent_items, effective_items, checked_txns);
        $display("tb: %0d inits, %0d flushes, %0d pixel writes, %0d contrast writes",
                 inits_run, flushes_run, pixel_writes, cfg_writes);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
